FILE: design/fcr_pkg.sv
// Shared types, constants and the pulse scaling function for the framed
// command receiver. No dependencies.
`timescale 1ns / 1ps

package fcr_pkg;

  localparam int unsigned PAYLOAD_LEN = 5;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned PULSE_W     = 11;

  // Frame positions
  localparam logic [POS_W-1:0] POS_IDLE  = 3'd0;
  localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
  localparam logic [POS_W-1:0] POS_STOP  = 3'd6;

  // Register indexes on the configuration port
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_STOP_MARKER  = 1'b1;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd255;
  localparam logic [BYTE_W-1:0] STOP_MARKER_RST  = 8'd254;

  // floor(b * 93 / 23) = floor(b * 93 * 22796 / 2^19) for every byte b:
  // 22796 = ceil(2^19 / 23), and b * 93 * (22796 * 23 - 2^19) < 2^19.
  localparam logic [21:0]        PULSE_MULT  = 22'd2120028;
  localparam int unsigned        PULSE_SHIFT = 19;
  localparam logic [PULSE_W-1:0] PULSE_BASE  = 11'd1000;

  typedef logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] payload_t;

  typedef struct packed {
    logic     commit;
    payload_t payload;
  } track_status_t;

  function automatic logic [PULSE_W-1:0] pulse_of(input logic [BYTE_W-1:0] b);
    logic [29:0]        prod;
    logic [PULSE_W-1:0] quot;
    prod = 30'(b) * 30'(PULSE_MULT);
    quot = prod[PULSE_SHIFT +: PULSE_W];
    return quot + PULSE_BASE;
  endfunction

endpackage

FILE: design/fcr_frame_track.sv
// Frame position tracker with scratch and committed payload stores.
// Depends on fcr_pkg.
`timescale 1ns / 1ps

module fcr_frame_track (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic [fcr_pkg::BYTE_W-1:0] rx_byte,
  input  logic [fcr_pkg::BYTE_W-1:0] start_marker,
  input  logic [fcr_pkg::BYTE_W-1:0] stop_marker,
  output fcr_pkg::track_status_t     status
);

  logic [fcr_pkg::POS_W-1:0] pos_r, pos_nxt;
  fcr_pkg::payload_t         scratch_r, scratch_nxt;
  fcr_pkg::payload_t         committed_r, committed_nxt;
  logic                      commit_r, commit_nxt;

  always_comb begin
    pos_nxt       = fcr_pkg::POS_IDLE;
    scratch_nxt   = scratch_r;
    committed_nxt = committed_r;
    commit_nxt    = 1'b0;
    case (pos_r)
      3'd1, 3'd2, 3'd3, 3'd4, 3'd5: begin
        for (int i = 0; i < fcr_pkg::PAYLOAD_LEN; i++) begin
          if (pos_r == fcr_pkg::POS_W'(i + 1)) begin
            scratch_nxt[i] = rx_byte;
          end
        end
        pos_nxt = pos_r + fcr_pkg::POS_FIRST;
      end
      fcr_pkg::POS_STOP: begin
        if (rx_byte == stop_marker) begin
          committed_nxt = scratch_r;
          commit_nxt    = 1'b1;
        end
      end
      default: begin
        pos_nxt = fcr_pkg::POS_IDLE;
      end
    endcase
    // start marker restarts the frame, even mid-frame
    if (rx_byte == start_marker) begin
      pos_nxt = fcr_pkg::POS_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= fcr_pkg::POS_IDLE;
      scratch_r   <= '0;
      committed_r <= '0;
      commit_r    <= 1'b0;
    end else if (step_en) begin
      pos_r       <= pos_nxt;
      scratch_r   <= scratch_nxt;
      committed_r <= committed_nxt;
      commit_r    <= commit_nxt;
    end
  end

  assign status.commit  = commit_r;
  assign status.payload = committed_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 3'd7)
    else $error("frame position left its range");

  a_commit_copies: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && pos_r == fcr_pkg::POS_STOP && rx_byte == stop_marker
    |=> commit_r && committed_r == $past(scratch_r))
    else $error("stop byte did not commit the scratch payload");

endmodule

FILE: design/framed_command_receiver.sv
// Top level of the framed command receiver: stream ports, configuration
// registers and output stage. Depends on fcr_pkg and fcr_frame_track.
`timescale 1ns / 1ps
//
//  channel | direction | transaction                       | width
//  --------+-----------+-----------------------------------+------------------
//  in_     | slave     | one received serial byte          | tdata 8
//  out_    | master    | commit flag, message, pulse pair  | tdata 64, tuser 1
//  cfg_    | APB slave | start / stop marker registers     | data 32, addr 3
//
//  The frame state updates at the edge that accepts a byte. The output
//  register loads the message and pulse values from stage one when free,
//  raising out_tvalid. A byte can be accepted every cycle unless out_tready
//  holds the output. Reset (rst_n, synchronous) clears the frame state, both
//  stores and returns the markers to their defaults. While out_tready is low
//  the output register holds, the stage behind it fills, then in_tready drops.

module framed_command_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,    // [7:0] payload_one, [15:8] payload_two,
                                    // [23:16] payload_three, [31:24] payload_four,
                                    // [39:32] payload_five, [50:40] pulse_a,
                                    // [61:51] pulse_b, [63:62] zero
  output logic        out_tuser,    // [0] frame_committed
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [fcr_pkg::BYTE_W-1:0] start_marker_r, stop_marker_r;
  logic                       cfg_wr;

  logic                       in_accept;
  logic                       out_free;
  logic                       s1_valid_r, s1_valid_nxt;
  fcr_pkg::track_status_t     track_status;

  logic                       out_valid_r;
  logic                       out_commit_r;
  fcr_pkg::payload_t          out_payload_r;
  logic [fcr_pkg::PULSE_W-1:0] out_pulse_a_r, out_pulse_b_r;

  // ---------------------------------------------------------------------------
  // Configuration: word-aligned registers, no wait states
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= fcr_pkg::START_MARKER_RST;
      stop_marker_r  <= fcr_pkg::STOP_MARKER_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        fcr_pkg::REG_START_MARKER: start_marker_r <= cfg_pwdata[7:0];
        fcr_pkg::REG_STOP_MARKER:  stop_marker_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      fcr_pkg::REG_START_MARKER: cfg_prdata = {24'd0, start_marker_r};
      fcr_pkg::REG_STOP_MARKER:  cfg_prdata = {24'd0, stop_marker_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: stage one is the frame state, stage two the output register.
  // Stage one's results stay put while it is valid, since no byte is accepted
  // until it drains.
  // ---------------------------------------------------------------------------
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end
  end

  fcr_frame_track u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (in_accept),
    .rx_byte      (in_tdata),
    .start_marker (start_marker_r),
    .stop_marker  (stop_marker_r),
    .status       (track_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // output payload: scale the first two committed bytes on the way through
  always_ff @(posedge clk) begin
    if (s1_valid_r && out_free) begin
      out_commit_r  <= track_status.commit;
      out_payload_r <= track_status.payload;
      out_pulse_a_r <= fcr_pkg::pulse_of(track_status.payload[0]);
      out_pulse_b_r <= fcr_pkg::pulse_of(track_status.payload[1]);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_commit_r;
  assign out_tdata  = {2'b00, out_pulse_b_r, out_pulse_a_r, out_payload_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted byte did not reach stage one");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(track_status))
    else $error("stage one lost or changed a waiting result");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pulse_a_r >= 11'd1000 && out_pulse_a_r <= 11'd2031 &&
                    out_pulse_b_r >= 11'd1000 && out_pulse_b_r <= 11'd2031)
    else $error("pulse value out of range");

  a_pulse_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pulse_a_r == fcr_pkg::pulse_of(out_payload_r[0]))
    else $error("pulse_a does not follow payload_one");

endmodule
